### src/video_dma_transfer_sequencer_assert.svh
// Assertion macros for the video DMA transfer sequencer.
// Used by the top level; assumes clk and rst_n exist in the including scope.
`ifndef VIDEO_DMA_TRANSFER_SEQUENCER_ASSERT_SVH
`define VIDEO_DMA_TRANSFER_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define VDTS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VDTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VDTS_ASSERT(label, ante, cons, msg)
`define VDTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/vdts_pkg.sv
// Shared types and codes for the video DMA transfer sequencer.
// No dependencies.
package vdts_pkg;

    typedef enum logic [1:0] {
        REQ_START       = 2'd0,
        REQ_FILL_DATA   = 2'd1,
        REQ_TICK        = 2'd2,
        REQ_READ_RETURN = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_BUS_READ    = 3'd1,
        OP_FIFO_WRITE  = 3'd2,
        OP_VRAM_WRITE  = 3'd3,
        OP_CRAM_WRITE  = 3'd4,
        OP_VSRAM_WRITE = 3'd5,
        OP_VRAM_READ   = 3'd6
    } op_t;

    // register indexes on the config port
    localparam logic [1:0] CFG_DMA_MODE     = 2'd0;
    localparam logic [1:0] CFG_DEST_TARGET  = 2'd1;
    localparam logic [1:0] CFG_ADDRESS_STEP = 2'd2;

    localparam logic [1:0] MODE_FILL = 2'd2;
    localparam logic [1:0] MODE_COPY = 2'd3;

    localparam logic [3:0] TGT_VRAM  = 4'd1;
    localparam logic [3:0] TGT_CRAM  = 4'd3;
    localparam logic [3:0] TGT_VSRAM = 4'd5;

    typedef struct packed {
        logic [1:0] dma_mode;
        logic [3:0] dest_target;
        logic [7:0] address_step;
    } vdts_cfg_t;

    typedef struct packed {
        logic        transfer_pending;
        logic        wait_flag;
        logic        data_ready;
        logic        bus_held;
        logic [21:0] source_word;
        logic [15:0] remaining;
        logic [16:0] dest_address;
        logic [15:0] data_latch;
    } vdts_state_t;

    // idle with wait set; everything else zero
    localparam vdts_state_t STATE_RESET = '{1'b0, 1'b1, 1'b0, 1'b0,
                                           22'd0, 16'd0, 17'd0, 16'd0};

    typedef struct packed {
        req_type_t   req_type;
        logic [21:0] start_source;
        logic [15:0] start_length;
        logic [16:0] start_dest;
        logic        hold_wait;
        logic [15:0] value;
        logic        fifo_full;
        logic        fifo_empty;
        logic        ram_busy;
    } vdts_req_t;

    typedef struct packed {
        op_t         op;
        logic [23:0] out_address;
        logic [3:0]  out_target;
        logic [15:0] out_data;
        logic        set_ram_busy;
        logic        bus_hold;
        logic        still_pending;
        logic        finished;
    } vdts_res_t;

endpackage

### src/vdts_req_if.sv
// Request channel of the video DMA transfer sequencer.
// Plain valid/ready channel; no dependencies.
interface vdts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [21:0] start_source;
    logic [15:0] start_length;
    logic [16:0] start_dest;
    logic        hold_wait;
    logic [15:0] value;
    logic        fifo_full;
    logic        fifo_empty;
    logic        ram_busy;

    modport source (
        output valid, req_type, start_source, start_length, start_dest,
               hold_wait, value, fifo_full, fifo_empty, ram_busy,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_source, start_length, start_dest,
               hold_wait, value, fifo_full, fifo_empty, ram_busy,
        output ready
    );
endinterface

### src/vdts_res_if.sv
// Result channel of the video DMA transfer sequencer.
// Plain valid/ready channel; no dependencies.
interface vdts_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [23:0] out_address;
    logic [3:0]  out_target;
    logic [15:0] out_data;
    logic        set_ram_busy;
    logic        bus_hold;
    logic        still_pending;
    logic        finished;

    modport source (
        output valid, op, out_address, out_target, out_data, set_ram_busy,
               bus_hold, still_pending, finished,
        input  ready
    );
    modport sink (
        input  valid, op, out_address, out_target, out_data, set_ram_busy,
               bus_hold, still_pending, finished,
        output ready
    );
endinterface

### src/vdts_core.sv
// Per-item next-state and result logic of the DMA sequencer.
// Depends on vdts_pkg.
module vdts_core
    import vdts_pkg::*;
(
    input  vdts_cfg_t   cfg,
    input  vdts_state_t state_cur,
    input  vdts_req_t   req_item,
    output vdts_state_t state_new,
    output vdts_res_t   result
);

    logic running;
    logic load_mode;
    logic do_advance;

    assign running   = state_cur.transfer_pending && !state_cur.wait_flag;
    assign load_mode = !cfg.dma_mode[1];

    always_comb
    begin
        state_new  = state_cur;
        result     = '0;
        result.op  = OP_NONE;
        do_advance = 1'b0;

        case (req_item.req_type)
            REQ_START:
            begin
                state_new.source_word      = req_item.start_source;
                state_new.remaining        = req_item.start_length;
                state_new.dest_address     = req_item.start_dest;
                state_new.wait_flag        = req_item.hold_wait;
                state_new.transfer_pending = 1'b1;
                state_new.data_ready       = 1'b0;
            end
            REQ_FILL_DATA:
            begin
                state_new.data_latch = req_item.value;
                state_new.wait_flag  = 1'b0;
                state_new.data_ready = 1'b0;
            end
            REQ_READ_RETURN:
            begin
                if (running && cfg.dma_mode != MODE_FILL && !state_cur.data_ready)
                begin
                    // copy mode keeps only the byte read
                    state_new.data_latch = (cfg.dma_mode == MODE_COPY)
                        ? {8'h00, req_item.value[7:0]} : req_item.value;
                    state_new.data_ready = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (running)
                begin
                    if (load_mode)
                    begin
                        if (state_cur.data_ready && !req_item.fifo_full)
                        begin
                            result.op          = OP_FIFO_WRITE;
                            result.out_address = {7'd0, state_cur.dest_address};
                            result.out_target  = cfg.dest_target;
                            result.out_data    = state_cur.data_latch;
                            state_new.data_ready = 1'b0;
                            do_advance = 1'b1;
                        end
                        else if (state_cur.bus_held && !state_cur.data_ready)
                        begin
                            result.op          = OP_BUS_READ;
                            result.out_address = {cfg.dma_mode[0],
                                                  state_cur.source_word, 1'b0};
                        end
                    end
                    else if (cfg.dma_mode == MODE_FILL)
                    begin
                        if (req_item.fifo_empty && !req_item.ram_busy)
                        begin
                            case (cfg.dest_target)
                                TGT_VRAM:
                                begin
                                    result.op          = OP_VRAM_WRITE;
                                    result.out_address = {7'd0,
                                        state_cur.dest_address ^ 17'd1};
                                    result.out_data    = {8'h00,
                                        state_cur.data_latch[15:8]};
                                end
                                TGT_CRAM:
                                begin
                                    result.op          = OP_CRAM_WRITE;
                                    result.out_address = {8'd0,
                                        state_cur.dest_address[16:1]};
                                    result.out_data    = state_cur.data_latch;
                                end
                                TGT_VSRAM:
                                begin
                                    result.op          = OP_VSRAM_WRITE;
                                    result.out_address = {8'd0,
                                        state_cur.dest_address[16:1]};
                                    result.out_data    = state_cur.data_latch;
                                end
                                default:
                                begin
                                    // unknown target: slot still consumed
                                end
                            endcase
                            result.set_ram_busy = 1'b1;
                            do_advance = 1'b1;
                        end
                    end
                    else if (!req_item.ram_busy)
                    begin
                        result.set_ram_busy = 1'b1;
                        if (!state_cur.data_ready)
                        begin
                            result.op          = OP_VRAM_READ;
                            result.out_address = {2'd0, state_cur.source_word ^ 22'd1};
                        end
                        else
                        begin
                            result.op          = OP_VRAM_WRITE;
                            result.out_address = {7'd0, state_cur.dest_address ^ 17'd1};
                            result.out_data    = {8'h00, state_cur.data_latch[7:0]};
                            state_new.data_ready = 1'b0;
                            do_advance = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_advance)
        begin
            // only the low 16 source bits wrap
            state_new.source_word  = {state_cur.source_word[21:16],
                                      state_cur.source_word[15:0] + 16'd1};
            state_new.dest_address = state_cur.dest_address + {9'd0, cfg.address_step};
            state_new.remaining    = state_cur.remaining - 16'd1;
            if (state_cur.remaining == 16'd1)
            begin
                state_new.transfer_pending = 1'b0;
                state_new.wait_flag        = 1'b1;
                result.finished            = 1'b1;
            end
        end

        state_new.bus_held = state_new.transfer_pending && !state_new.wait_flag
                             && load_mode;
        result.bus_hold      = state_new.bus_held;
        result.still_pending = state_new.transfer_pending;
    end

endmodule

### src/video_dma_transfer_sequencer.sv
// Video DMA transfer sequencer: start/fill/tick/read-return items in, one result per item.
// The result is registered: it is valid in the cycle after its item is accepted.
// Throughput: 1 item per cycle while the sink keeps taking results; the result register frees as the sink takes it.
// Reset: async active-low; transfer idle, wait set, config registers zero.
// Depends on vdts_pkg, vdts_req_if, vdts_res_if, vdts_core and the assert header.
`include "video_dma_transfer_sequencer_assert.svh"
module video_dma_transfer_sequencer
    import vdts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    vdts_req_if.sink    req,
    vdts_res_if.source  res
);

    vdts_cfg_t   cfg_reg;
    vdts_state_t state_reg;
    vdts_state_t state_next;
    vdts_req_t   req_item;
    vdts_res_t   res_next;
    vdts_res_t   res_reg;
    logic        res_valid_reg;
    logic        accept;

    // Item accepted whenever the result register is empty or being drained.
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign req_item.req_type     = req_type_t'(req.req_type);
    assign req_item.start_source = req.start_source;
    assign req_item.start_length = req.start_length;
    assign req_item.start_dest   = req.start_dest;
    assign req_item.hold_wait    = req.hold_wait;
    assign req_item.value        = req.value;
    assign req_item.fifo_full    = req.fifo_full;
    assign req_item.fifo_empty   = req.fifo_empty;
    assign req_item.ram_busy     = req.ram_busy;

    // Config writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DMA_MODE:     cfg_reg.dma_mode     <= cfg_data[1:0];
                CFG_DEST_TARGET:  cfg_reg.dest_target  <= cfg_data[3:0];
                CFG_ADDRESS_STEP: cfg_reg.address_step <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    vdts_core u_core (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .req_item  (req_item),
        .state_new (state_next),
        .result    (res_next)
    );

    // Transfer state moves only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.op            = res_reg.op;
    assign res.out_address   = res_reg.out_address;
    assign res.out_target    = res_reg.out_target;
    assign res.out_data      = res_reg.out_data;
    assign res.set_ram_busy  = res_reg.set_ram_busy;
    assign res.bus_hold      = res_reg.bus_hold;
    assign res.still_pending = res_reg.still_pending;
    assign res.finished      = res_reg.finished;

    `VDTS_ASSERT(a_done_clears_pending, res_valid_reg && res_reg.finished, !res_reg.still_pending, "finished result still pending")
    `VDTS_ASSERT(a_hold_needs_pending, res_valid_reg && res_reg.bus_hold, res_reg.still_pending, "bus held with no transfer pending")
    `VDTS_ASSERT(a_idle_op_zero, res_valid_reg && res_reg.op == OP_NONE, res_reg.out_address == 24'd0 && res_reg.out_data == 16'd0 && res_reg.out_target == 4'd0, "no-op result carries payload")
    `VDTS_ASSERT_NEXT(a_accept_gives_result, accept, res_valid_reg, "accepted item produced no result")

endmodule

### tb/sv/video_dma_transfer_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for video_dma_transfer_sequencer: directed and random items
// through all four DMA modes, each result checked against a cycle-free model.
// Depends on vdts_pkg, vdts_req_if, vdts_res_if and the block itself.
module video_dma_transfer_sequencer_tb;
    import vdts_pkg::*;

    localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS   = 100;   // random items per configuration phase
    localparam int RANDOM_PHASES = 16;

    // one queued item plus a flag that holds it back until all results are in
    typedef struct {
        vdts_req_t body;
        bit        drain_first;
    } queued_req_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    vdts_req_if req_ch ();
    vdts_res_if res_ch ();

    video_dma_transfer_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Model copy of the DMA registers and the configuration
    // ------------------------------------------------------------------
    vdts_state_t dma_st;
    vdts_cfg_t   dma_cfg;

    queued_req_t req_backlog[$];       // items not yet offered
    vdts_res_t   awaited_results[$];   // predicted results, oldest first
    vdts_req_t   in_flight;            // item currently on the request channel

    int send_idle_pct;
    int stall_pct;
    int mismatch_count;
    int quiet_cycles;

    // One finished transfer: low 16 source bits wrap, destination steps, count drops.
    // Returns 1 when the count hits zero (a length of 0 therefore runs 65536 times).
    function automatic logic count_transfer();
        dma_st.source_word[15:0] = dma_st.source_word[15:0] + 16'd1;
        dma_st.dest_address      = dma_st.dest_address + 17'(dma_cfg.address_step);
        dma_st.remaining         = dma_st.remaining - 16'd1;
        if (dma_st.remaining == 16'd0)
        begin
            dma_st.transfer_pending = 1'b0;
            dma_st.wait_flag        = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Result of one accepted item; updates the model state as a side effect.
    function automatic vdts_res_t sequencer_step(input vdts_req_t rq);
        vdts_res_t o;
        logic      running;
        logic      load_mode;
        o         = '0;
        running   = dma_st.transfer_pending && !dma_st.wait_flag;
        load_mode = !dma_cfg.dma_mode[1];   // modes 0 and 1 fetch from the system bus
        case (rq.req_type)
            REQ_START:
            begin
                // a start also replaces a transfer that is still running
                dma_st.source_word      = rq.start_source;
                dma_st.remaining        = rq.start_length;
                dma_st.dest_address     = rq.start_dest;
                dma_st.wait_flag        = rq.hold_wait;
                dma_st.transfer_pending = 1'b1;
                dma_st.data_ready       = 1'b0;
            end
            REQ_FILL_DATA:
            begin
                dma_st.data_latch = rq.value;
                dma_st.wait_flag  = 1'b0;
                dma_st.data_ready = 1'b0;
            end
            REQ_READ_RETURN:
            begin
                // dropped unless a fetch can actually be waiting for it
                if (running && dma_cfg.dma_mode != MODE_FILL && !dma_st.data_ready)
                begin
                    dma_st.data_latch = (dma_cfg.dma_mode == MODE_COPY)
                                        ? {8'h00, rq.value[7:0]} : rq.value;
                    dma_st.data_ready = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (running && load_mode)
                begin
                    if (dma_st.data_ready && !rq.fifo_full)
                    begin
                        o.op          = OP_FIFO_WRITE;
                        o.out_address = {7'd0, dma_st.dest_address};
                        o.out_target  = dma_cfg.dest_target;
                        o.out_data    = dma_st.data_latch;
                        dma_st.data_ready = 1'b0;
                        o.finished    = count_transfer();
                    end
                    else if (dma_st.bus_held && !dma_st.data_ready)
                    begin
                        // reissued on every tick until the data returns
                        o.op          = OP_BUS_READ;
                        o.out_address = {dma_cfg.dma_mode[0], dma_st.source_word, 1'b0};
                    end
                end
                else if (running && dma_cfg.dma_mode == MODE_FILL)
                begin
                    if (rq.fifo_empty && !rq.ram_busy)
                    begin
                        case (dma_cfg.dest_target)
                            TGT_VRAM:
                            begin
                                o.op          = OP_VRAM_WRITE;
                                o.out_address = {7'd0, dma_st.dest_address ^ 17'd1};
                                o.out_data    = {8'h00, dma_st.data_latch[15:8]};
                            end
                            TGT_CRAM:
                            begin
                                o.op          = OP_CRAM_WRITE;
                                o.out_address = {8'd0, dma_st.dest_address[16:1]};
                                o.out_data    = dma_st.data_latch;
                            end
                            TGT_VSRAM:
                            begin
                                o.op          = OP_VSRAM_WRITE;
                                o.out_address = {8'd0, dma_st.dest_address[16:1]};
                                o.out_data    = dma_st.data_latch;
                            end
                            default: ;  // unknown target: nothing written, slot still used
                        endcase
                        o.set_ram_busy = 1'b1;
                        o.finished     = count_transfer();
                    end
                end
                else if (running && !rq.ram_busy)
                begin
                    // copy: read a byte, then write it on a later tick
                    o.set_ram_busy = 1'b1;
                    if (!dma_st.data_ready)
                    begin
                        o.op          = OP_VRAM_READ;
                        o.out_address = {2'd0, dma_st.source_word ^ 22'd1};
                    end
                    else
                    begin
                        o.op          = OP_VRAM_WRITE;
                        o.out_address = {7'd0, dma_st.dest_address ^ 17'd1};
                        o.out_data    = {8'h00, dma_st.data_latch[7:0]};
                        dma_st.data_ready = 1'b0;
                        o.finished    = count_transfer();
                    end
                end
            end
        endcase
        // bus hold follows every item, whatever its type
        dma_st.bus_held = dma_st.transfer_pending && !dma_st.wait_flag && load_mode;
        o.bus_hold      = dma_st.bus_held;
        o.still_pending = dma_st.transfer_pending;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic vdts_req_t mk_req(input req_type_t kind, input logic [21:0] src,
                                         input logic [15:0] len, input logic [16:0] dst,
                                         input logic hold, input logic [15:0] val,
                                         input logic full, input logic empty,
                                         input logic busy);
        vdts_req_t r;
        r.req_type     = kind;
        r.start_source = src;
        r.start_length = len;
        r.start_dest   = dst;
        r.hold_wait    = hold;
        r.value        = val;
        r.fifo_full    = full;
        r.fifo_empty   = empty;
        r.ram_busy     = busy;
        return r;
    endfunction

    // random payload; flags leaning toward the states that let a transfer move
    function automatic vdts_req_t shaped_req(input req_type_t kind);
        return mk_req(kind, 22'($urandom), 16'($urandom), 17'($urandom), 1'($urandom),
                      16'($urandom), $urandom_range(3) == 0, $urandom_range(4) != 0,
                      $urandom_range(3) == 0);
    endfunction

    task automatic push(input vdts_req_t r);
        req_backlog.push_back('{body: r, drain_first: 1'b0});
    endtask

    // Mostly well-formed transfers with random content, plus noise and
    // broken sequences (dropped fill data, stray items mid-transfer).
    task automatic fill_phase(input int budget, input logic [1:0] mode);
        vdts_req_t r;
        int        body;
        int        made;
        made = 0;
        while (made < budget)
        begin
            if ($urandom_range(99) < 10)
            begin
                push(shaped_req(req_type_t'($urandom_range(3))));
                made++;
            end
            else
            begin
                r = shaped_req(REQ_START);
                // short counts mostly; now and then a full-range one that gets cut off
                r.start_length = ($urandom_range(9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(1, 5));
                r.hold_wait    = (mode == MODE_FILL) ? ($urandom_range(9) != 0)
                                                     : 1'($urandom);
                push(r);
                made++;
                if (r.hold_wait && $urandom_range(9) != 0)
                begin
                    push(shaped_req(REQ_FILL_DATA));
                    made++;
                end
                body = (r.start_length == 16'd0 || r.start_length > 16'd8)
                       ? 8 : int'(r.start_length);
                body = (mode == MODE_FILL) ? body + 2 : 3 * body + 2;
                for (int k = 0; k < body; k++)
                begin
                    if ($urandom_range(99) < 12)
                        push(shaped_req(req_type_t'($urandom_range(3))));
                    else if (mode != MODE_FILL && k % 3 == 1)
                        push(shaped_req(REQ_READ_RETURN));
                    else
                        push(shaped_req(REQ_TICK));
                    made++;
                end
            end
        end
    endtask

    // register writes go straight into the model too; only called while idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_DMA_MODE:     dma_cfg.dma_mode     = data[1:0];
            CFG_DEST_TARGET:  dma_cfg.dest_target  = data[3:0];
            CFG_ADDRESS_STEP: dma_cfg.address_step = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [3:0] tgt,
                              input logic [7:0] step);
        write_reg(CFG_DMA_MODE, {6'd0, mode});
        write_reg(CFG_DEST_TARGET, {4'd0, tgt});
        write_reg(CFG_ADDRESS_STEP, step);
        cfg_we <= 1'b0;
    endtask

    // every item offered, accepted and answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_ch.valid || awaited_results.size() != 0);
        repeat (2) @(posedge clk);   // registered result stage, plus margin
    endtask

    // ------------------------------------------------------------------
    // Request driver: predicts on accept, then offers the next item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        queued_req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                awaited_results.push_back(sequencer_step(in_flight));
            if (!req_ch.valid || req_ch.ready)
            begin
                // hold-off items wait until nothing is outstanding
                if (req_backlog.size() == 0 || $urandom_range(99) < send_idle_pct
                    || (req_backlog[0].drain_first && awaited_results.size() != 0))
                begin
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    nxt = req_backlog.pop_front();
                    in_flight           <= nxt.body;
                    req_ch.valid        <= 1'b1;
                    req_ch.req_type     <= nxt.body.req_type;
                    req_ch.start_source <= nxt.body.start_source;
                    req_ch.start_length <= nxt.body.start_length;
                    req_ch.start_dest   <= nxt.body.start_dest;
                    req_ch.hold_wait    <= nxt.body.hold_wait;
                    req_ch.value        <= nxt.body.value;
                    req_ch.fifo_full    <= nxt.body.fifo_full;
                    req_ch.fifo_empty   <= nxt.body.fifo_empty;
                    req_ch.ram_busy     <= nxt.body.ram_busy;
                end
            end
        end
    end

    // result sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        vdts_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing outstanding: op %0d", res_ch.op);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("op",            want.op,            res_ch.op);
                check_field("out_address",   want.out_address,   res_ch.out_address);
                check_field("out_target",    want.out_target,    res_ch.out_target);
                check_field("out_data",      want.out_data,      res_ch.out_data);
                check_field("set_ram_busy",  want.set_ram_busy,  res_ch.set_ram_busy);
                check_field("bus_hold",      want.bus_hold,      res_ch.bus_hold);
                check_field("still_pending", want.still_pending, res_ch.still_pending);
                check_field("finished",      want.finished,      res_ch.finished);
            end
        end
    end

    // watchdog: any handshake on either side counts as progress
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [3:0] tgt;
        logic [7:0] step;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DMA_MODE;
        cfg_data            = 8'd0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_TICK;
        req_ch.start_source = '0;
        req_ch.start_length = '0;
        req_ch.start_dest   = '0;
        req_ch.hold_wait    = 1'b0;
        req_ch.value        = '0;
        req_ch.fifo_full    = 1'b0;
        req_ch.fifo_empty   = 1'b0;
        req_ch.ram_busy     = 1'b0;
        res_ch.ready        = 1'b0;
        in_flight           = '0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        mismatch_count      = 0;
        quiet_cycles        = 0;
        dma_cfg             = '0;
        dma_st              = '0;
        dma_st.wait_flag    = 1'b1;   // idle and waiting after reset

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: memory load, mode 1 so the high source bit shows ---
        set_config(2'd1, 4'd15, 8'd255);
        push(mk_req(REQ_START, 22'h3FFFFF, 16'd2, 17'h1FFFF, 1'b1, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));  // waiting
        push(mk_req(REQ_FILL_DATA, 22'h0, 16'h0, 17'h0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));  // bus read
        push(mk_req(REQ_READ_RETURN, 22'h0, 16'h0, 17'h0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        // second return while data is already held: dropped
        push(mk_req(REQ_READ_RETURN, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b1, 1'b0, 1'b0));  // FIFO full
        // FIFO write; source low half wraps, destination wraps by the step
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_READ_RETURN, 22'h0, 16'h0, 17'h0, 1'b0, 16'h1234, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));  // last one
        // zero length means 65536 transfers; cut short below by a new start
        push(mk_req(REQ_START, 22'h0, 16'd0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_READ_RETURN, 22'h0, 16'h0, 17'h0, 1'b0, 16'hABCD, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_START, 22'h155555, 16'd1, 17'h0AAAA, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_FILL_DATA, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // --- directed: fill into VRAM, gated by FIFO empty and RAM busy ---
        set_config(MODE_FILL, TGT_VRAM, 8'd1);
        push(mk_req(REQ_START, 22'h0, 16'd3, 17'h1FFFF, 1'b1, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_FILL_DATA, 22'h0, 16'h0, 17'h0, 1'b0, 16'hFF00, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b1, 1'b1));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b1, 1'b0));
        wait_drained();

        // --- directed: VRAM copy, only the low byte of the read survives ---
        set_config(MODE_COPY, 4'd0, 8'd2);
        push(mk_req(REQ_START, 22'h000001, 16'd1, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b1));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_READ_RETURN, 22'h0, 16'h0, 17'h0, 1'b0, 16'hBEEF, 1'b0, 1'b0, 1'b0));
        push(mk_req(REQ_TICK, 22'h0, 16'h0, 17'h0, 1'b0, 16'h0, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // --- random phases ---
        // mode cycles fastest; idling changes every four phases:
        // none, sender 48%, receiver 48%, both 27%
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                2:       tgt = TGT_VRAM;
                6:       tgt = TGT_CRAM;
                10:      tgt = TGT_VSRAM;
                14:      tgt = 4'd15;       // fill to a target with no memory behind it
                default: tgt = 4'($urandom);
            endcase
            case (p % 3)
                0:       step = 8'd0;
                1:       step = 8'd255;
                default: step = 8'($urandom);
            endcase
            set_config(2'(p % 4), tgt, step);
            case ((p / 4) % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 48; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            fill_phase(PHASE_ITEMS, 2'(p % 4));
            // mid-phase pause until the pipeline is empty
            req_backlog[40].drain_first = 1'b1;
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
